// ===== rtl/core/kvt_pkg.sv =====
// Shared types and constants for the key/value table.
// Used by kvt_cell, kvt_reduce and key_value_table; depends on nothing.
package kvt_pkg;

    // Operation codes carried by the mode field of a request.
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Fixed field widths of a request and a result.
    localparam int MODE_W  = 2;
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    // The match reduction tree combines this many nodes per registered level.
    localparam int TREE_RADIX_LOG = 3;
    localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic compare;  // register the key match of this cell
        logic upd;      // overwrite the value of the matching slot
        logic app;      // write a new entry into the first free slot
        logic del;      // shift entries down from the matching slot on
    } t_cell_ctrl;

    // Control states of the request sequencer.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_TREE  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/kvt_cell.sv =====
// One slot of the key/value chain: stored key and value, key compare, neighbor shift.
// Depends on kvt_pkg for the command struct and field widths.
module kvt_cell #(
    parameter int DEPTH    = 128,
    parameter int KEY_BITS = 64,
    parameter int INDEX    = 0
) (
    input  logic                                 i_clk,
    input  kvt_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [$clog2(DEPTH)-1:0]             i_slot,
    input  logic [$clog2(DEPTH+1)-1:0]           i_count,
    input  logic [KEY_BITS-1:0]                  i_key,
    input  logic [kvt_pkg::VALUE_W-1:0]          i_value,
    input  logic [KEY_BITS-1:0]                  i_next_key,
    input  logic [kvt_pkg::VALUE_W-1:0]          i_next_value,
    output logic [KEY_BITS-1:0]                  o_key,
    output logic [kvt_pkg::VALUE_W-1:0]          o_value,
    output logic                                 o_match
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] POS_C = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] POS_S = IDX_W'(INDEX);

    logic [KEY_BITS-1:0]         r_key;
    logic [kvt_pkg::VALUE_W-1:0] r_value;
    logic                        r_match;

    // Key compare; a slot at or above the live count never matches.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare) begin
            r_match <= (POS_C < i_count) && (r_key == i_key);
        end
    end

    // Storage update: append, overwrite or take the neighbor's entry on removal.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.app && (POS_C == i_count)) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctrl.upd && (POS_S == i_slot)) begin
            r_value <= i_value;
        end else if (i_ctrl.del && (POS_S >= i_slot)) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== rtl/core/kvt_reduce.sv =====
// Registered OR tree that gathers the found flag, value and slot of the matching cell.
// Depends on kvt_pkg for the tree radix and value width.
module kvt_reduce #(
    parameter int DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic [DEPTH-1:0]                  i_match,
    input  logic [kvt_pkg::VALUE_W-1:0]       i_value [DEPTH],
    output logic                              o_found,
    output logic [kvt_pkg::VALUE_W-1:0]       o_value,
    output logic [$clog2(DEPTH)-1:0]          o_slot
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int EW     = 1 + kvt_pkg::VALUE_W + IDX_W;
    localparam int LEVELS = ($clog2(DEPTH) + kvt_pkg::TREE_RADIX_LOG - 1)
                            / kvt_pkg::TREE_RADIX_LOG;

    logic [EW-1:0] n_leaf [DEPTH];
    logic [EW-1:0] n_lvl  [LEVELS][DEPTH];
    logic [EW-1:0] r_lvl  [LEVELS][DEPTH];

    // Leaf entries: a matching cell contributes its flag, value and position.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_match[i]) begin
                n_leaf[i] = {1'b1, i_value[i], IDX_W'(i)};
            end else begin
                n_leaf[i] = '0;
            end
        end
    end

    // Each level merges groups of nodes of the level below; at most one leaf is set.
    for (genvar l = 0; l < LEVELS; l++) begin : gen_lvl
        localparam int NPREV = (DEPTH + (1 << (kvt_pkg::TREE_RADIX_LOG * l)) - 1)
                               >> (kvt_pkg::TREE_RADIX_LOG * l);
        localparam int NODES = (NPREV + kvt_pkg::TREE_RADIX - 1) / kvt_pkg::TREE_RADIX;

        always_comb begin
            for (int j = 0; j < DEPTH; j++) begin
                n_lvl[l][j] = '0;
                if (j < NODES) begin
                    for (int c = 0; c < kvt_pkg::TREE_RADIX; c++) begin
                        if (j * kvt_pkg::TREE_RADIX + c < NPREV) begin
                            if (l == 0) begin
                                n_lvl[l][j] = n_lvl[l][j]
                                    | n_leaf[j * kvt_pkg::TREE_RADIX + c];
                            end else begin
                                n_lvl[l][j] = n_lvl[l][j]
                                    | r_lvl[(l > 0) ? l - 1 : 0][j * kvt_pkg::TREE_RADIX + c];
                            end
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < DEPTH; j++) begin
                r_lvl[l][j] <= n_lvl[l][j];
            end
        end
    end

    // The root node of the last level holds the lookup result.
    assign o_found = r_lvl[LEVELS-1][0][EW-1];
    assign o_value = r_lvl[LEVELS-1][0][EW-2:IDX_W];
    assign o_slot  = r_lvl[LEVELS-1][0][IDX_W-1:0];

endmodule

// ===== rtl/core/key_value_table.sv =====
// Key/value table: one request at a time, accepted only while the sequencer is idle.
// A request goes through the key compare, the match tree of LEVELS = ceil(log8(TABLE_DEPTH))
// registered levels and the apply state, which writes the result register and holds while
// a waiting result is stalled; a new request is taken only once the sequencer is idle again.
// Reset clears the live count, the sequencer and the result valid; key and value
// storage is not cleared, since slots at or above the live count are never read.
module key_value_table #(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_BITS    = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [kvt_pkg::MODE_W-1:0]         i_mode,
    input  logic [kvt_pkg::KEY_W-1:0]          i_key,
    input  logic signed [kvt_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [kvt_pkg::VALUE_W-1:0] o_read_value,
    output logic [kvt_pkg::COUNT_W-1:0]        o_entry_count
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEVELS = ($clog2(TABLE_DEPTH) + kvt_pkg::TREE_RADIX_LOG - 1)
                            / kvt_pkg::TREE_RADIX_LOG;
    localparam int LC_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(TABLE_DEPTH);

    kvt_pkg::t_state               r_state, n_state;
    logic [LC_W-1:0]               r_lvl_cnt;
    logic [CNT_W-1:0]              r_count;
    logic [kvt_pkg::MODE_W-1:0]    r_req_mode;
    logic [KEY_BITS-1:0]           r_req_key;
    logic [kvt_pkg::VALUE_W-1:0]   r_req_value;
    logic                          r_out_valid;
    logic [1:0]                    r_out_status;
    logic [kvt_pkg::VALUE_W-1:0]   r_out_value;
    logic [kvt_pkg::COUNT_W-1:0]   r_out_count;

    kvt_pkg::t_cell_ctrl           w_ctrl;
    logic [KEY_BITS-1:0]           w_key   [TABLE_DEPTH];
    logic [kvt_pkg::VALUE_W-1:0]   w_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        w_match;
    logic                          w_found;
    logic [kvt_pkg::VALUE_W-1:0]   w_found_value;
    logic [IDX_W-1:0]              w_slot;
    logic                          w_in_acc;
    logic                          w_adv;
    logic                          w_room;
    logic [1:0]                    n_status;
    logic [kvt_pkg::VALUE_W-1:0]   n_rd;
    logic [CNT_W-1:0]              n_count;

    assign w_in_acc = i_in_valid && (r_state == kvt_pkg::S_IDLE);
    assign w_adv    = (r_state == kvt_pkg::S_APPLY) && !(r_out_valid && i_out_stall);
    assign w_room   = r_count < FULL_C;

    // Sequencer: compare, walk the match tree, then apply and post the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = kvt_pkg::S_CMP;
                end
            end
            kvt_pkg::S_CMP: begin
                n_state = kvt_pkg::S_TREE;
            end
            kvt_pkg::S_TREE: begin
                if (r_lvl_cnt == LC_W'(LEVELS - 1)) begin
                    n_state = kvt_pkg::S_APPLY;
                end
            end
            kvt_pkg::S_APPLY: begin
                if (w_adv) begin
                    n_state = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kvt_pkg::S_IDLE;
            r_lvl_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == kvt_pkg::S_TREE) begin
                r_lvl_cnt <= r_lvl_cnt + 1'b1;
            end else begin
                r_lvl_cnt <= '0;
            end
        end
    end

    // Request register; held while the request is being worked on.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req_mode  <= i_mode;
            r_req_key   <= i_key[KEY_BITS-1:0];
            r_req_value <= i_value;
        end
    end

    // Commands to the cell chain.
    always_comb begin
        w_ctrl.compare = (r_state == kvt_pkg::S_CMP);
        w_ctrl.upd     = w_adv && (r_req_mode == kvt_pkg::MODE_PUT) && w_found;
        w_ctrl.app     = w_adv && (r_req_mode == kvt_pkg::MODE_PUT) && !w_found && w_room;
        w_ctrl.del     = w_adv && (r_req_mode == kvt_pkg::MODE_REMOVE) && w_found;
    end

    // Chain of slots; each one takes its upper neighbor's entry on removal.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : gen_cell
        localparam int NXT = (i + 1 < TABLE_DEPTH) ? i + 1 : i;
        kvt_cell #(
            .DEPTH    (TABLE_DEPTH),
            .KEY_BITS (KEY_BITS),
            .INDEX    (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_slot       (w_slot),
            .i_count      (r_count),
            .i_key        (r_req_key),
            .i_value      (r_req_value),
            .i_next_key   (w_key[NXT]),
            .i_next_value (w_value[NXT]),
            .o_key        (w_key[i]),
            .o_value      (w_value[i]),
            .o_match      (w_match[i])
        );
    end

    kvt_reduce #(
        .DEPTH (TABLE_DEPTH)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_match (w_match),
        .i_value (w_value),
        .o_found (w_found),
        .o_value (w_found_value),
        .o_slot  (w_slot)
    );

    // Result fields and the live count after this request.
    always_comb begin
        n_status = kvt_pkg::STATUS_OK;
        n_rd     = '0;
        n_count  = r_count;
        case (r_req_mode)
            kvt_pkg::MODE_PUT: begin
                if (!w_found) begin
                    if (w_room) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_status = kvt_pkg::STATUS_FULL;
                    end
                end
            end
            kvt_pkg::MODE_GET: begin
                if (w_found) begin
                    n_rd = w_found_value;
                end else begin
                    n_status = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            kvt_pkg::MODE_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = kvt_pkg::STATUS_NOT_FOUND;
                end
            end
            default: begin
                n_status = kvt_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_adv) begin
            r_count <= n_count;
        end
    end

    // Output register; a stalled waiting result holds the sequencer in apply and so blocks the next request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= n_status;
            r_out_value  <= n_rd;
            r_out_count  <= kvt_pkg::COUNT_W'(n_count);
        end
    end

    assign o_in_stall    = (r_state != kvt_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = $signed(r_out_value);
    assign o_entry_count = r_out_count;

    // The live count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("live count exceeds table depth");

    // Keys in the table are unique, so at most one cell matches.
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvt_pkg::S_TREE) |-> $onehot0(w_match))
        else $error("more than one slot matches the key");

    // A removal that hits shrinks the table by exactly one entry.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.del |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not decrement the live count");

    // A dropped put is reported only when the table is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (n_status == kvt_pkg::STATUS_FULL)) |-> (r_count == FULL_C))
        else $error("full status with free slots left");

endmodule
